// ===== rtl/sfcc_pkg.sv =====
// shared types, constants and the crc-8 byte step for the sensor frame converter
// no dependencies
`default_nettype none

package sfcc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int TEMP_SCALE  = 17500;
    localparam int TEMP_OFFSET = 4500;
    localparam int HUMI_SCALE  = 10000;

    localparam int TEMP_W   = 15;
    localparam int HUMI_W   = 14;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 16;

    localparam int OUT_BITS   = TEMP_W + HUMI_W + STATUS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        POS_TEMP_MSB = 3'd0,
        POS_TEMP_LSB = 3'd1,
        POS_TEMP_CRC = 3'd2,
        POS_HUMI_MSB = 3'd3,
        POS_HUMI_LSB = 3'd4,
        POS_HUMI_CRC = 3'd5
    } pos_t;

    typedef struct packed {
        logic                  done;
        logic [WORD_W-1:0]     temp_word;
        logic [WORD_W-1:0]     humi_word;
        logic [STATUS_W-1:0]   crc_status;
    } frame_t;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sfcc_frame.sv =====
// byte position sequencer, running crc check and raw word capture
// depends on sfcc_pkg
`default_nettype none

module sfcc_frame (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            take,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            frame_start,
    output sfcc_pkg::frame_t     frame
);
    import sfcc_pkg::*;

    pos_t              pos_reg, pos_next;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        hold_reg, hold_next;
    logic [WORD_W-1:0] temp_word_reg, temp_word_next;
    logic [WORD_W-1:0] humi_word_reg, humi_word_next;
    logic              temp_bad_reg, temp_bad_next;
    pos_t              pos_eff;

    always_comb begin
        pos_eff = pos_reg;
        if (frame_start) begin
            pos_eff = POS_TEMP_MSB;
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        hold_next      = hold_reg;
        temp_word_next = temp_word_reg;
        humi_word_next = humi_word_reg;
        temp_bad_next  = temp_bad_reg;
        frame          = '0;
        frame.temp_word = temp_word_reg;
        frame.humi_word = humi_word_reg;
        frame.crc_status = {crc_reg != rx_byte, temp_bad_reg};
        if (take) begin
            unique case (pos_eff)
                POS_TEMP_LSB: begin
                    crc_next       = crc_byte(crc_reg, rx_byte);
                    temp_word_next = {hold_reg, rx_byte};
                    pos_next       = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    temp_bad_next = (crc_reg != rx_byte);
                    crc_next      = CRC_INIT;
                    pos_next      = POS_HUMI_MSB;
                end
                POS_HUMI_MSB: begin
                    crc_next  = crc_byte(CRC_INIT, rx_byte);
                    hold_next = rx_byte;
                    pos_next  = POS_HUMI_LSB;
                end
                POS_HUMI_LSB: begin
                    crc_next       = crc_byte(crc_reg, rx_byte);
                    humi_word_next = {hold_reg, rx_byte};
                    pos_next       = POS_HUMI_CRC;
                end
                POS_HUMI_CRC: begin
                    frame.done = 1'b1;
                    crc_next   = CRC_INIT;
                    pos_next   = POS_TEMP_MSB;
                end
                default: begin
                    // temperature msb, also taken for out-of-range positions
                    crc_next  = crc_byte(CRC_INIT, rx_byte);
                    hold_next = rx_byte;
                    pos_next  = POS_TEMP_LSB;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_TEMP_MSB;
            crc_reg      <= CRC_INIT;
            temp_bad_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            temp_bad_reg <= temp_bad_next;
        end
        hold_reg      <= hold_next;
        temp_word_reg <= temp_word_next;
        humi_word_reg <= humi_word_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sfcc_convert.sv =====
// fixed-point scaling of the raw words and the result register
// depends on sfcc_pkg
`default_nettype none

module sfcc_convert (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire sfcc_pkg::frame_t                   frame,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic [sfcc_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                    out_free
);
    import sfcc_pkg::*;

    localparam int TPROD_W = WORD_W + TEMP_W;
    localparam int HPROD_W = WORD_W + HUMI_W;

    logic                   valid_reg, valid_next;
    logic [OUT_DATA_W-1:0]  data_reg, data_next;
    logic [TPROD_W-1:0]     temp_prod;
    logic [HPROD_W-1:0]     humi_prod;
    logic [TEMP_W-1:0]      temp_centi;
    logic [HUMI_W-1:0]      humi_centi;

    assign temp_prod  = TPROD_W'(frame.temp_word) * TPROD_W'(TEMP_SCALE);
    assign humi_prod  = HPROD_W'(frame.humi_word) * HPROD_W'(HUMI_SCALE);
    assign temp_centi = temp_prod[TPROD_W-1:WORD_W] - TEMP_W'(TEMP_OFFSET);
    assign humi_centi = humi_prod[HPROD_W-1:WORD_W];

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (out_free) begin
            valid_next = frame.done;
            if (frame.done) begin
                data_next = OUT_DATA_W'({frame.crc_status, humi_centi, temp_centi});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/sensor_frame_crc_convert_top.sv =====
// top level: input register, frame sequencer with crc check, conversion and result register
// depends on sfcc_pkg, sfcc_frame, sfcc_convert
//
// channel   direction  data                                   user
// s_        in         rx_byte[7:0]                           frame_start
// m_        out        temp_centi, humi_centi, crc_status     -
//
// one item per cycle sustained while the result is not stalled; a byte waits in the input register
// until taken, and the sixth byte of a frame shows its result from the result register
// the throughput is set by the combinational crc byte step and the constant multiplies
// reset clears the input and result valid flags and the frame position
// a stalled result holds the input register; a byte is taken whenever the result slot frees
`default_nettype none

module sensor_frame_crc_convert_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // rx_byte[7:0]
    input  wire logic                               s_tuser,   // frame_start
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // temp_centi[14:0], humi_centi[28:15], crc_status[30:29], zero[31]
    output logic [sfcc_pkg::OUT_DATA_W-1:0]         m_tdata
);
    import sfcc_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_start_reg, in_start_next;
    logic       out_free;
    logic       take;
    frame_t     frame;

    assign take     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_start_next = in_start_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_start_next = s_tuser;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_byte_reg  <= in_byte_next;
        in_start_reg <= in_start_next;
    end

    sfcc_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .frame       (frame)
    );

    sfcc_convert u_convert (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .frame    (frame),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .out_free (out_free)
    );

endmodule

`default_nettype wire
